/* sv/dclf_pkg.sv */
// Shared types and constants for the dual channel link framer.
// Used by the transmit bank, the receive lanes and the top level.
package dclf_pkg;

   localparam int unsigned BUF_DEPTH       = 16;
   localparam int unsigned IDX_W           = $clog2(BUF_DEPTH);
   localparam int unsigned ADDR_W          = IDX_W + 1;
   localparam int unsigned WORD_W          = 16;
   localparam int unsigned FRAME_LAST_DEF  = 13;
   localparam int unsigned CHANNELS_DEF    = 2;
   localparam int unsigned PORT_CHANNELS   = 2;

   localparam logic [WORD_W-1:0] SYNC_WORD    = 16'hfefe;
   localparam logic [7:0]        RESTART_MODE = 8'd8;

   typedef enum logic [2:0] {
      OP_XFER  = 3'd0,
      OP_WRITE = 3'd1,
      OP_START = 3'd2,
      OP_READ  = 3'd3,
      OP_CLEAR = 3'd4
   } op_type;

   // Decoded beat for the transmit bank, qualified by the input handshake.
   // beat is high for every accepted request, whatever its op.
   typedef struct packed {
      logic              beat;
      logic              xfer;
      logic              wr;
      logic              start;
      logic [IDX_W-1:0]  idx;
      logic [WORD_W-1:0] wval;
   } tx_cmd_type;

   // Decoded beat for one receive lane; rd and clr already match the lane.
   typedef struct packed {
      logic              xfer;
      logic              rd;
      logic              clr;
      logic              parent;
      logic [IDX_W-1:0]  idx;
   } rx_cmd_type;

endpackage

/* sv/dclf_tx_bank.sv */
// Transmit side: ping-pong send memory and the send position walker.
// Depends on dclf_pkg.
module dclf_tx_bank
   import dclf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  tx_cmd_type        cmd,
   output logic              tx_valid,
   output logic [WORD_W-1:0] tx_word
);

   localparam logic signed [IDX_W:0] POS_IDLE = -(IDX_W+1)'(2);
   localparam logic signed [IDX_W:0] POS_SYNC = -(IDX_W+1)'(1);
   localparam logic signed [IDX_W:0] POS_LAST = (IDX_W+1)'(BUF_DEPTH - 1);

   logic [WORD_W-1:0]        mem [0:2*BUF_DEPTH-1];
   logic [WORD_W-1:0]        rdata_ff;
   logic signed [IDX_W:0]    pos_ff, pos_in;
   logic                     bank_ff, bank_in;
   logic                     valid_ff, valid_in;
   logic                     sync_ff, sync_in;
   logic                     rd_en;

   always_comb begin
      pos_in   = pos_ff;
      bank_in  = bank_ff;
      valid_in = valid_ff;
      sync_in  = sync_ff;
      rd_en    = 1'b0;
      if (cmd.xfer) begin
         valid_in = 1'b0;
         sync_in  = 1'b0;
         if (pos_ff == POS_SYNC) begin
            valid_in = 1'b1;
            sync_in  = 1'b1;
            bank_in  = ~bank_ff;
         end else if (!pos_ff[IDX_W]) begin
            valid_in = 1'b1;
            rd_en    = 1'b1;
         end
         if (pos_ff < POS_LAST) begin
            pos_in = pos_ff + (IDX_W+1)'(1);
         end
      end else if (cmd.beat) begin
         // any other accepted op sends nothing; hold while no beat is taken
         valid_in = 1'b0;
         sync_in  = 1'b0;
         if (cmd.start) begin
            pos_in = POS_SYNC;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_IDLE;
         bank_ff  <= 1'b0;
         valid_ff <= 1'b0;
         sync_ff  <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         bank_ff  <= bank_in;
         valid_ff <= valid_in;
         sync_ff  <= sync_in;
      end
   end

   // Filling bank takes software writes; the other bank is sent.
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[{bank_ff, cmd.idx}] <= cmd.wval;
      end
      if (rd_en) begin
         rdata_ff <= mem[{~bank_ff, pos_ff[IDX_W-1:0]}];
      end
   end

   assign tx_valid = valid_ff;
   assign tx_word  = !valid_ff ? '0 : (sync_ff ? SYNC_WORD : rdata_ff);

endmodule

/* sv/dclf_rx_lane.sv */
// One receive channel: incoming/ready bank memory, word position and flags.
// Depends on dclf_pkg.
module dclf_rx_lane
   import dclf_pkg::*;
#(
   parameter int unsigned FRAME_LAST = FRAME_LAST_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  rx_cmd_type        cmd,
   input  logic [WORD_W-1:0] rx_word,
   output logic [1:0]        flags,
   output logic [WORD_W-1:0] rdata
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LAST);
   localparam logic [IDX_W-1:0] TOP_IDX  = IDX_W'(BUF_DEPTH - 1);

   logic [WORD_W-1:0] mem [0:2*BUF_DEPTH-1];
   logic [WORD_W-1:0] rdata_ff;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic              bank_ff, bank_in;
   logic [1:0]        flags_ff, flags_in;
   logic              sync_hit;
   logic              wr_en;

   assign sync_hit = (rx_word == SYNC_WORD) && (pos_ff > LAST_IDX);

   always_comb begin
      pos_in   = pos_ff;
      bank_in  = bank_ff;
      flags_in = flags_ff;
      wr_en    = 1'b0;
      if (cmd.xfer) begin
         if (sync_hit) begin
            pos_in = '0;
         end else begin
            wr_en = 1'b1;
            if (pos_ff == LAST_IDX) begin
               bank_in     = ~bank_ff;
               flags_in[0] = 1'b1;
            end
            if (pos_ff != TOP_IDX) begin
               pos_in = pos_ff + IDX_W'(1);
            end
         end
         if (cmd.parent) begin
            flags_in[1] = 1'b1;
         end
      end else if (cmd.clr) begin
         flags_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= TOP_IDX;
         bank_ff  <= 1'b0;
         flags_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         bank_ff  <= bank_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{bank_ff, pos_ff}] <= rx_word;
      end
      if (cmd.rd) begin
         rdata_ff <= mem[{~bank_ff, cmd.idx}];
      end
   end

   assign flags = flags_ff;
   assign rdata = rdata_ff;

endmodule

/* sv/dual_channel_link_framer_unit.sv */
// Dual channel link framer, top level.
// Request channel (req_*): one beat per op. Op 0 is a link transfer event that
// sends one halfword and takes one received halfword per channel; ops 1..4
// write a send word, start a frame, read a ready word and clear flags.
// Response channel (rsp_*): exactly one beat per request beat, in order.
// Config channel (csr_*): writes link_mode; write it only while no request
// is outstanding.
// Response timing: a response is valid in the cycle after its request is accepted,
// as the reads of the send and receive memories are registered.
// Throughput: one request per cycle; the read registers of the memories are
// the response register, so a request is taken whenever the response slot
// is empty or is drained in the same cycle.
// Stall: while rsp_stall holds a pending response, req_stall is raised and
// all state but link_mode, and the response, hold.
// Reset: synchronous; the transmitter goes idle, receive channels await sync,
// flags, parent latch and link_mode clear. The memories are not cleared.
// Depends on dclf_pkg, dclf_tx_bank, dclf_rx_lane.
module dual_channel_link_framer_unit
   import dclf_pkg::*;
#(
   parameter int unsigned FRAME_LAST = FRAME_LAST_DEF,
   parameter int unsigned CHANNELS   = CHANNELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_op,
   input  logic [WORD_W-1:0] req_rx_word_a,
   input  logic [WORD_W-1:0] req_rx_word_b,
   input  logic              req_parent_bit,
   input  logic              req_chan_sel,
   input  logic [IDX_W-1:0]  req_entry_index,
   input  logic [WORD_W-1:0] req_write_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_tx_valid,
   output logic [WORD_W-1:0] rsp_tx_word,
   output logic [1:0]        rsp_flags_a,
   output logic [1:0]        rsp_flags_b,
   output logic [WORD_W-1:0] rsp_read_data,
   output logic              rsp_restart_pulse,
   output logic              rsp_parent_mode,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);

   localparam int unsigned LANES = (CHANNELS > PORT_CHANNELS) ? PORT_CHANNELS : CHANNELS;

   logic              accept;
   logic              is_xfer, is_write, is_start, is_read, is_clear;
   logic              sel_ok;
   tx_cmd_type        tx_cmd;
   logic [WORD_W-1:0] lane_word  [PORT_CHANNELS];
   logic [1:0]        lane_flags [PORT_CHANNELS];
   logic [WORD_W-1:0] lane_rdata [PORT_CHANNELS];

   logic       rsp_valid_ff, rsp_valid_in;
   logic       restart_ff, restart_in;
   logic       parent_ff, parent_in;
   logic       rd_en_ff, rd_en_in;
   logic       rd_sel_ff, rd_sel_in;
   logic [7:0] link_mode_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign sel_ok    = (LANES > 1) || !req_chan_sel;

   always_comb begin
      is_xfer  = 1'b0;
      is_write = 1'b0;
      is_start = 1'b0;
      is_read  = 1'b0;
      is_clear = 1'b0;
      unique case (op_type'(req_op))
         OP_XFER:  is_xfer  = accept;
         OP_WRITE: is_write = accept;
         OP_START: is_start = accept;
         OP_READ:  is_read  = accept;
         OP_CLEAR: is_clear = accept;
         default:  ;
      endcase
   end

   assign tx_cmd.beat  = accept;
   assign tx_cmd.xfer  = is_xfer;
   assign tx_cmd.wr    = is_write;
   assign tx_cmd.start = is_start;
   assign tx_cmd.idx   = req_entry_index;
   assign tx_cmd.wval  = req_write_value;

   dclf_tx_bank u_tx (
      .clock    (clock),
      .reset    (reset),
      .cmd      (tx_cmd),
      .tx_valid (rsp_tx_valid),
      .tx_word  (rsp_tx_word)
   );

   assign lane_word[0] = req_rx_word_a;
   assign lane_word[1] = req_rx_word_b;

   for (genvar c = 0; c < PORT_CHANNELS; c++) begin : g_lane
      if (c < LANES) begin : g_on
         rx_cmd_type cmd;
         assign cmd.xfer   = is_xfer;
         assign cmd.rd     = is_read && (req_chan_sel == 1'(c));
         assign cmd.clr    = is_clear && (req_chan_sel == 1'(c));
         assign cmd.parent = req_parent_bit;
         assign cmd.idx    = req_entry_index;

         dclf_rx_lane #(
            .FRAME_LAST (FRAME_LAST)
         ) u_lane (
            .clock   (clock),
            .reset   (reset),
            .cmd     (cmd),
            .rx_word (lane_word[c]),
            .flags   (lane_flags[c]),
            .rdata   (lane_rdata[c])
         );
      end else begin : g_off
         assign lane_flags[c] = '0;
         assign lane_rdata[c] = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      restart_in   = restart_ff;
      parent_in    = parent_ff;
      rd_en_in     = rd_en_ff;
      rd_sel_in    = rd_sel_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         restart_in   = is_xfer && (link_mode_ff == RESTART_MODE);
         rd_en_in     = is_read && sel_ok;
         rd_sel_in    = req_chan_sel;
         if (is_xfer) begin
            parent_in = req_parent_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         restart_ff   <= 1'b0;
         parent_ff    <= 1'b0;
         rd_en_ff     <= 1'b0;
         rd_sel_ff    <= 1'b0;
         link_mode_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         restart_ff   <= restart_in;
         parent_ff    <= parent_in;
         rd_en_ff     <= rd_en_in;
         rd_sel_ff    <= rd_sel_in;
         if (csr_valid && csr_ready) begin
            link_mode_ff <= csr_data;
         end
      end
   end

   // Flags and parent latch change only on accepted beats, so they hold the
   // state left by the op now shown on the response.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_flags_a       = lane_flags[0];
   assign rsp_flags_b       = lane_flags[1];
   assign rsp_read_data     = rd_en_ff ? lane_rdata[rd_sel_ff] : '0;
   assign rsp_restart_pulse = restart_ff;
   assign rsp_parent_mode   = parent_ff;

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

   a_restart_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_restart_pulse |-> link_mode_ff == RESTART_MODE)
      else $error("restart pulse without restart mode");

   a_tx_word_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_valid |-> rsp_tx_word == '0)
      else $error("transmit word present without transmit valid");

   a_read_data_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_read_data != '0 |-> rd_en_ff)
      else $error("read data present outside a ready read");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking regression bench for dual_channel_link_framer_unit.
// Depends on dclf_pkg and the framer top level; predicts every response beat in-line.
module testbench;
   import dclf_pkg::*;

   localparam logic [2:0] OP_SPARE_A  = 3'd5;
   localparam logic [2:0] OP_SPARE_B  = 3'd6;
   localparam logic [2:0] OP_SPARE_C  = 3'd7;
   localparam int         CYCLE_LIMIT = 300000;
   localparam int         IDX_LAST    = BUF_DEPTH - 1;

   typedef struct {
      logic [2:0]        op;
      logic [WORD_W-1:0] word_a;
      logic [WORD_W-1:0] word_b;
      logic              parent;
      logic              sel;
      logic [IDX_W-1:0]  idx;
      logic [WORD_W-1:0] wval;
   } link_req_type;

   typedef struct packed {
      logic              tx_valid;
      logic [WORD_W-1:0] tx_word;
      logic [1:0]        flags_a;
      logic [1:0]        flags_b;
      logic [WORD_W-1:0] read_data;
      logic              restart;
      logic              parent;
   } link_status_type;

   logic              clock;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_stall;
   logic [2:0]        req_op          = '0;
   logic [WORD_W-1:0] req_rx_word_a   = '0;
   logic [WORD_W-1:0] req_rx_word_b   = '0;
   logic              req_parent_bit  = 1'b0;
   logic              req_chan_sel    = 1'b0;
   logic [IDX_W-1:0]  req_entry_index = '0;
   logic [WORD_W-1:0] req_write_value = '0;
   logic              rsp_valid;
   logic              rsp_stall       = 1'b0;
   logic              rsp_tx_valid;
   logic [WORD_W-1:0] rsp_tx_word;
   logic [1:0]        rsp_flags_a;
   logic [1:0]        rsp_flags_b;
   logic [WORD_W-1:0] rsp_read_data;
   logic              rsp_restart_pulse;
   logic              rsp_parent_mode;
   logic              csr_valid       = 1'b0;
   logic              csr_ready;
   logic [7:0]        csr_data        = '0;

   // shadow of the framer state
   int                tx_pos          = -2;
   logic              tx_bank         = 1'b0;
   logic [WORD_W-1:0] tx_mem [2][BUF_DEPTH];
   logic [IDX_W-1:0]  rx_pos [2]      = '{4'd15, 4'd15};
   logic              rx_bank [2]     = '{1'b0, 1'b0};
   logic [WORD_W-1:0] rx_mem [2][2][BUF_DEPTH];
   bit                rx_written [2][2][BUF_DEPTH];
   logic [1:0]        chan_flags [2]  = '{2'd0, 2'd0};
   logic              parent_latch    = 1'b0;
   logic [7:0]        link_mode       = 8'd0;

   link_status_type   status_due[$];
   int                error_count     = 0;
   int                cycle_count     = 0;
   int                send_gap_pct    = 0;
   int                rsp_stall_pct   = 0;
   int                hold_left       = 0;

   dual_channel_link_framer_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_rx_word_a     (req_rx_word_a),
      .req_rx_word_b     (req_rx_word_b),
      .req_parent_bit    (req_parent_bit),
      .req_chan_sel      (req_chan_sel),
      .req_entry_index   (req_entry_index),
      .req_write_value   (req_write_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tx_valid      (rsp_tx_valid),
      .rsp_tx_word       (rsp_tx_word),
      .rsp_flags_a       (rsp_flags_a),
      .rsp_flags_b       (rsp_flags_b),
      .rsp_read_data     (rsp_read_data),
      .rsp_restart_pulse (rsp_restart_pulse),
      .rsp_parent_mode   (rsp_parent_mode),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("dual_channel_link_framer_unit regression: fail");
         $finish;
      end
   end

   // receiver side: long hold-off when requested, otherwise random stall
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      error_count++;
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
   endtask

   task automatic compare_field(input string what, input logic [WORD_W-1:0] got,
                                input logic [WORD_W-1:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      link_status_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (status_due.size() == 0) begin
            report_mismatch("unexpected beat", '0, '0);
         end else begin
            want = status_due.pop_front();
            compare_field("tx_valid", WORD_W'(rsp_tx_valid), WORD_W'(want.tx_valid));
            compare_field("tx_word", rsp_tx_word, want.tx_word);
            compare_field("flags_a", WORD_W'(rsp_flags_a), WORD_W'(want.flags_a));
            compare_field("flags_b", WORD_W'(rsp_flags_b), WORD_W'(want.flags_b));
            compare_field("read_data", rsp_read_data, want.read_data);
            compare_field("restart_pulse", WORD_W'(rsp_restart_pulse),
                          WORD_W'(want.restart));
            compare_field("parent_mode", WORD_W'(rsp_parent_mode), WORD_W'(want.parent));
         end
      end
   end

   // Advance the shadow state by one accepted beat and return its status.
   function automatic link_status_type step_link(input link_req_type r);
      link_status_type   s;
      logic [WORD_W-1:0] w;
      logic [IDX_W-1:0]  pos;
      s = '0;
      unique case (r.op)
         OP_XFER: begin
            parent_latch = r.parent;
            if (tx_pos == -1) begin
               s.tx_valid = 1'b1;
               s.tx_word  = SYNC_WORD;
               tx_bank    = ~tx_bank;
            end else if (tx_pos >= 0) begin
               s.tx_valid = 1'b1;
               s.tx_word  = tx_mem[~tx_bank][tx_pos];
            end
            if (tx_pos < IDX_LAST)
               tx_pos++;
            for (int c = 0; c < 2; c++) begin
               w   = (c == 0) ? r.word_a : r.word_b;
               pos = rx_pos[c];
               if (w == SYNC_WORD && pos > FRAME_LAST_DEF) begin
                  pos = '0;
               end else begin
                  rx_mem[c][rx_bank[c]][pos]     = w;
                  rx_written[c][rx_bank[c]][pos] = 1'b1;
                  if (pos == FRAME_LAST_DEF) begin
                     rx_bank[c]       = ~rx_bank[c];
                     chan_flags[c][0] = 1'b1;
                  end
                  if (pos < IDX_LAST)
                     pos++;
               end
               if (parent_latch)
                  chan_flags[c][1] = 1'b1;
               rx_pos[c] = pos;
            end
            s.restart = (link_mode == RESTART_MODE);
         end
         OP_WRITE: tx_mem[tx_bank][r.idx] = r.wval;
         OP_START: tx_pos = -1;
         OP_READ:  s.read_data = rx_mem[r.sel][~rx_bank[r.sel]][r.idx];
         OP_CLEAR: chan_flags[r.sel] = 2'd0;
         default: ;
      endcase
      s.flags_a = chan_flags[0];
      s.flags_b = chan_flags[1];
      s.parent  = parent_latch;
      return s;
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      unique case ($urandom_range(0, 15))
         0:       return 16'h0000;
         1:       return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   // favor sync once a lane has a full frame, so lanes keep restarting
   function automatic logic [WORD_W-1:0] pick_rx_word(input int c);
      if (rx_pos[c] > FRAME_LAST_DEF && $urandom_range(0, 2) == 0)
         return SYNC_WORD;
      if ($urandom_range(0, 24) == 0)
         return SYNC_WORD;
      return pick_word();
   endfunction

   function automatic link_req_type blank_request(input logic [2:0] op);
      link_req_type r;
      r.op     = op;
      r.word_a = pick_word();
      r.word_b = pick_word();
      r.parent = 1'($urandom);
      r.sel    = 1'($urandom);
      r.idx    = 4'($urandom);
      r.wval   = pick_word();
      return r;
   endfunction

   // Steer a ready-word read onto a written entry, or make it a clear if there is none.
   function automatic link_req_type guard_read(input link_req_type r);
      int               k;
      int               base;
      logic             c;
      logic [IDX_W-1:0] i;
      if (r.op != OP_READ || rx_written[r.sel][~rx_bank[r.sel]][r.idx])
         return r;
      base = $urandom_range(0, 31);
      for (k = 0; k < 32; k++) begin
         c = 1'((base + k) >> 4);
         i = 4'(base + k);
         if (rx_written[c][~rx_bank[c]][i]) begin
            r.sel = c;
            r.idx = i;
            return r;
         end
      end
      r.op = OP_CLEAR;
      return r;
   endfunction

   function automatic link_req_type make_request();
      link_req_type r;
      int           roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         r = blank_request(OP_XFER);
      else if (roll < 67)
         r = blank_request(OP_WRITE);
      else if (roll < 72)
         r = blank_request(OP_START);
      else if (roll < 87)
         r = blank_request(OP_READ);
      else if (roll < 95)
         r = blank_request(OP_CLEAR);
      else if (roll < 97)
         r = blank_request(OP_SPARE_A);
      else if (roll < 99)
         r = blank_request(OP_SPARE_B);
      else
         r = blank_request(OP_SPARE_C);
      r.word_a = pick_rx_word(0);
      r.word_b = pick_rx_word(1);
      return guard_read(r);
   endfunction

   task automatic send_item(input link_req_type r);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= r.op;
      req_rx_word_a   <= r.word_a;
      req_rx_word_b   <= r.word_b;
      req_parent_bit  <= r.parent;
      req_chan_sel    <= r.sel;
      req_entry_index <= r.idx;
      req_write_value <= r.wval;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      status_due.push_back(step_link(r));
   endtask

   // drop valid and wait for every outstanding beat to come back
   task automatic settle_link();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (status_due.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_link_mode(input logic [7:0] value);
      settle_link();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      link_mode = value;
   endtask

   // Fill both send banks so no transmit beat ever reads an empty entry.
   task automatic test_bank_fill();
      link_req_type r;
      for (int b = 0; b < 2; b++) begin
         for (int i = 0; i < BUF_DEPTH; i++) begin
            r      = blank_request(OP_WRITE);
            r.idx  = 4'(i);
            r.wval = (i == 0) ? 16'h0000 : (i == IDX_LAST) ? 16'hffff : pick_word();
            send_item(r);
         end
         if (b == 0) begin
            // idle transmitter; lanes store a non-sync word at the saturated slot
            r        = blank_request(OP_XFER);
            r.word_a = 16'h0000;
            r.word_b = 16'hffff;
            r.parent = 1'b0;
            send_item(r);
            // sync goes out and the banks swap; lanes restart on sync
            r        = blank_request(OP_XFER);
            r.word_a = SYNC_WORD;
            r.word_b = SYNC_WORD;
            r.parent = 1'b0;
            send_item(r);
         end
      end
   endtask

   task automatic test_tx_sequencing();
      link_req_type r;
      send_item(blank_request(OP_START));
      r        = blank_request(OP_XFER);
      r.word_a = 16'hffff;
      r.word_b = 16'h0000;
      r.parent = 1'b1;
      send_item(r);
      r        = blank_request(OP_XFER);
      r.parent = 1'b0;
      send_item(r);
      send_item(blank_request(OP_SPARE_A));
      send_item(blank_request(OP_SPARE_B));
      send_item(blank_request(OP_SPARE_C));
      r     = blank_request(OP_CLEAR);
      r.sel = 1'b0;
      send_item(r);
      r.sel = 1'b1;
      send_item(r);
   endtask

   task automatic test_frame_capture();
      link_req_type r;
      // run both lanes through the last frame word, then resync at slot 14
      while (rx_pos[0] <= FRAME_LAST_DEF)
         send_item(blank_request(OP_XFER));
      r        = blank_request(OP_XFER);
      r.word_a = SYNC_WORD;
      r.word_b = SYNC_WORD;
      send_item(r);
      r     = blank_request(OP_READ);
      r.sel = 1'b0;
      r.idx = 4'd0;
      send_item(guard_read(r));
      r.sel = 1'b1;
      r.idx = 4'(FRAME_LAST_DEF);
      send_item(guard_read(r));
      r.idx = 4'(IDX_LAST);
      send_item(guard_read(r));
      r     = blank_request(OP_CLEAR);
      r.sel = 1'b0;
      send_item(r);
   endtask

   task automatic test_random_traffic(input int count);
      repeat (count)
         send_item(make_request());
   endtask

   task automatic test_backpressure();
      hold_left = 80;
      test_random_traffic(40);
      settle_link();
      test_random_traffic(20);
   endtask

   initial begin
      send_gap_pct  = 21;
      rsp_stall_pct = 54;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_link_mode(RESTART_MODE);
      test_bank_fill();
      test_tx_sequencing();
      test_frame_capture();

      write_link_mode(8'hff);
      test_random_traffic(540);

      send_gap_pct  = 54;
      rsp_stall_pct = 21;
      write_link_mode(8'h00);
      test_random_traffic(540);

      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      write_link_mode(8'($urandom));
      test_random_traffic(540);

      write_link_mode(RESTART_MODE);
      test_backpressure();

      settle_link();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("dual_channel_link_framer_unit regression: pass");
      else
         $display("dual_channel_link_framer_unit regression: fail");
      $finish;
   end

endmodule
